>>> rtl/core/tdr_pkg.sv
// Package for the triangle depth rasterizer: screen size, fixed-point widths,
// opcodes and the sequencer state type. No dependencies.
package tdr_pkg;

   // Screen and depth store geometry.
   localparam int SCREEN_WIDTH  = 256;
   localparam int SCREEN_HEIGHT = 256;
   localparam int DEPTH_ENTRIES = 65536;
   localparam int ADDR_W        = 16;
   localparam logic signed [15:0] DEPTH_FAR = 16'sh8000;

   // Datapath widths: edge sums, their magnitudes and weight quotients.
   localparam int ACC_W = 38;
   localparam int MAG_W = 37;
   localparam int QUO_W = 15;
   localparam int OPD_W = 18;

   // Command codes.
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_TEST  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Sequencer states, one-hot.
   typedef enum logic [6:0] {
      ST_WIPE  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_EDGE  = 7'b0000100,
      ST_CHECK = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_DEPTH = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

endpackage

>>> rtl/core/tdr_req_if.sv
// Command channel interface of the triangle depth rasterizer.
// Depends on nothing; field widths follow the command format.
interface tdr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [1:0]         vertex_index;
   logic signed [15:0] vert_x;
   logic signed [15:0] vert_y;
   logic signed [15:0] vert_z;
   logic [7:0]         pixel_x;
   logic [7:0]         pixel_y;

   modport source (output valid, opcode, vertex_index, vert_x, vert_y, vert_z,
                   pixel_x, pixel_y, input ready);
   modport sink (input valid, opcode, vertex_index, vert_x, vert_y, vert_z,
                 pixel_x, pixel_y, output ready);
endinterface

>>> rtl/core/tdr_rsp_if.sv
// Result channel interface of the triangle depth rasterizer.
// Depends on nothing; field widths follow the result format.
interface tdr_rsp_if;
   logic               valid;
   logic               ready;
   logic               visible;
   logic [7:0]         out_x;
   logic [7:0]         out_y;
   logic signed [15:0] depth;
   logic signed [15:0] weight_a;
   logic signed [15:0] weight_b;
   logic signed [15:0] weight_c;

   modport source (output valid, visible, out_x, out_y, depth, weight_a, weight_b,
                   weight_c, input ready);
   modport sink (input valid, visible, out_x, out_y, depth, weight_a, weight_b,
                 weight_c, output ready);
endinterface

>>> rtl/core/tdr_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module tdr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/core/tdr_div.sv
// Restoring divider for one barycentric weight: round(n * 16384 / d), one
// quotient bit per cycle. Depends on tdr_pkg.
module tdr_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tdr_pkg::MAG_W-1:0] num_mag,
   input  logic [tdr_pkg::MAG_W-1:0] den_mag,
   output logic                      done,
   output logic [tdr_pkg::QUO_W-1:0] quot
);

   localparam int REM_W = tdr_pkg::MAG_W + tdr_pkg::QUO_W + 1;
   localparam int CNT_W = $clog2(tdr_pkg::QUO_W);

   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [REM_W-1:0]          dsh_ff, dsh_in;
   logic [tdr_pkg::QUO_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      run_ff, run_in;
   logic                      done_ff, done_in;
   logic                      ovf_ff, ovf_in;
   logic                      fits;
   logic [REM_W-1:0]          init_rem;

   // The dividend is 2n*2^14 + d and the divisor 2d, so the floor gives rounding.
   // A quotient too large for the register is flagged and reads as all ones,
   // which the weight clamp turns into full scale.
   always_comb begin
      fits     = rem_ff >= dsh_ff;
      init_rem = (REM_W'(num_mag) << (tdr_pkg::QUO_W)) + REM_W'(den_mag);
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      ovf_in   = ovf_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in  = init_rem;
         dsh_in  = REM_W'(den_mag) << (tdr_pkg::QUO_W);
         ovf_in  = init_rem >= (REM_W'(den_mag) << (tdr_pkg::QUO_W + 1));
         quot_in = '0;
         cnt_in  = CNT_W'(tdr_pkg::QUO_W - 1);
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[tdr_pkg::QUO_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      ovf_ff  <= ovf_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = ovf_ff ? '1 : quot_ff;

endmodule

>>> rtl/core/triangle_depth_rasterizer.sv
// Top level of the triangle depth rasterizer: sequencer, shared multiplier,
// vertex registers and depth memory. Depends on tdr_pkg, tdr_req_if, tdr_rsp_if,
// tdr_ram and tdr_div.
//
//   Channel   Direction  Carries
//   req_if    in         load vertex, test pixel or clear depth entry
//   rsp_if    out        one result per pixel test
//
// Loads and clears complete at their transfer. A pixel test inside the triangle
// passes through these steps in order: the transfer, multiply-accumulate steps
// for the edge values, the inside check and the depth read, the two weight
// dividers, the depth sum and the depth compare and update. A test outside the
// triangle skips the division and depth sum; an off-screen test goes from the
// transfer straight to the compare and result.
// After reset a wipe pass writes the far depth to all 65536 entries, one per
// cycle, while no command is accepted. A test holds in its last state while
// the result register is still full and not being taken.
module triangle_depth_rasterizer (
   input logic clock,
   input logic reset,
   tdr_req_if.sink   req_if,
   tdr_rsp_if.source rsp_if
);

   localparam int AW = tdr_pkg::ADDR_W;
   localparam int OW = tdr_pkg::OPD_W;
   localparam int CW = tdr_pkg::ACC_W;

   tdr_pkg::state_type state_ff, state_in;
   logic [2:0]          step_ff, step_in;
   logic [AW-1:0]       wipe_ff, wipe_in;
   logic [7:0]          px_ff, px_in, py_ff, py_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic                zero_ff, zero_in;
   logic signed [CW-1:0] acc_ff, acc_in, a_ff, a_in, s_ff, s_in, t_ff, t_in;
   logic signed [15:0]  vx_ff [3];
   logic signed [15:0]  vy_ff [3];
   logic signed [15:0]  vz_ff [3];
   logic                rvalid_ff, rvalid_in, rvis_ff, rvis_in;
   logic [7:0]          rx_ff, rx_in, ry_ff, ry_in;
   logic signed [15:0]  rdepth_ff, rdepth_in, rwa_ff, rwa_in, rwb_ff, rwb_in;
   logic signed [15:0]  rwc_ff, rwc_in;

   logic                on_screen, accept, load_vtx, slot_free, covered;
   logic [AW-1:0]       req_idx;
   logic signed [OW-1:0] op_a, op_b;
   logic signed [2*OW-1:0] prod;
   logic signed [CW-1:0] sum;
   logic signed [CW:0]  st_sum;
   logic signed [OW-1:0] pxq, pyq;
   logic                ram_we, ram_re;
   logic [AW-1:0]       ram_waddr;
   logic [15:0]         ram_wdata, ram_rdata;
   logic                div_start, div_b_done, div_c_done;
   logic [tdr_pkg::MAG_W-1:0] s_mag, t_mag, a_mag;
   logic [tdr_pkg::QUO_W-1:0] qb, qc;
   logic signed [16:0]  wb_raw, wc_raw;
   logic signed [16:0]  wb, wc, wa;
   logic signed [17:0]  wa_raw;
   logic signed [CW-1:0] zsh;
   logic signed [15:0]  znew;
   logic                nearer;

   // Depth memory.
   tdr_ram #(.WIDTH(16), .DEPTH(tdr_pkg::DEPTH_ENTRIES)) u_depth (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   // Weight dividers for the second and third vertex, run side by side.
   tdr_div u_div_b (
      .clock (clock), .reset (reset), .start (div_start),
      .num_mag (s_mag), .den_mag (a_mag), .done (div_b_done), .quot (qb)
   );
   tdr_div u_div_c (
      .clock (clock), .reset (reset), .start (div_start),
      .num_mag (t_mag), .den_mag (a_mag), .done (div_c_done), .quot (qc)
   );

   // Command decode on the request side.
   always_comb begin
      on_screen = (int'(req_if.pixel_x) < tdr_pkg::SCREEN_WIDTH) &&
                  (int'(req_if.pixel_y) < tdr_pkg::SCREEN_HEIGHT);
      req_idx   = AW'(int'(req_if.pixel_x) +
                      int'(req_if.pixel_y) * tdr_pkg::SCREEN_WIDTH);
      accept    = req_if.valid && req_if.ready;
      load_vtx  = accept && (req_if.opcode == tdr_pkg::OP_LOAD) &&
                  (req_if.vertex_index != 2'd3);
   end

   // Magnitudes and signs of the edge values, and the weights built from them.
   // The first weight comes from the unclamped second and third weights.
   always_comb begin
      s_mag  = s_ff[CW-1] ? tdr_pkg::MAG_W'(-s_ff) : tdr_pkg::MAG_W'(s_ff);
      t_mag  = t_ff[CW-1] ? tdr_pkg::MAG_W'(-t_ff) : tdr_pkg::MAG_W'(t_ff);
      a_mag  = a_ff[CW-1] ? tdr_pkg::MAG_W'(-a_ff) : tdr_pkg::MAG_W'(a_ff);
      wb_raw = (s_ff[CW-1] != a_ff[CW-1]) ? -$signed({2'b00, qb}) : $signed({2'b00, qb});
      wc_raw = (t_ff[CW-1] != a_ff[CW-1]) ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
      wa_raw = 18'sd16384 - 18'(wb_raw) - 18'(wc_raw);
      if (wa_raw > 18'sd16384) begin
         wa = 17'sd16384;
      end else if (wa_raw < -18'sd16384) begin
         wa = -17'sd16384;
      end else begin
         wa = 17'(wa_raw);
      end
      if (wb_raw > 17'sd16384) begin
         wb = 17'sd16384;
      end else if (wb_raw < -17'sd16384) begin
         wb = -17'sd16384;
      end else begin
         wb = wb_raw;
      end
      if (wc_raw > 17'sd16384) begin
         wc = 17'sd16384;
      end else if (wc_raw < -17'sd16384) begin
         wc = -17'sd16384;
      end else begin
         wc = wc_raw;
      end
      st_sum = (CW+1)'(s_ff) + (CW+1)'(t_ff);
      if (a_ff == '0 || (s_ff[CW-1] != t_ff[CW-1])) begin
         covered = 1'b0;
      end else if (a_ff[CW-1]) begin
         covered = (s_ff <= 0) && (st_sum >= (CW+1)'(a_ff));
      end else begin
         covered = (s_ff >= 0) && (st_sum <= (CW+1)'(a_ff));
      end
   end

   // Shared multiplier: edge products first, then the depth terms.
   always_comb begin
      pxq  = OW'($signed({1'b0, px_ff, 4'b0000}));
      pyq  = OW'($signed({1'b0, py_ff, 4'b0000}));
      op_a = '0;
      op_b = '0;
      if (state_ff == tdr_pkg::ST_DEPTH) begin
         case (step_ff)
            3'd0:    begin op_a = OW'(wa); op_b = OW'(vz_ff[0]); end
            3'd1:    begin op_a = OW'(wb); op_b = OW'(vz_ff[1]); end
            default: begin op_a = OW'(wc); op_b = OW'(vz_ff[2]); end
         endcase
      end else begin
         case (step_ff)
            3'd0: begin
               op_a = OW'(vx_ff[1]) - OW'(vx_ff[0]); op_b = OW'(vy_ff[2]) - OW'(vy_ff[0]);
            end
            3'd1: begin
               op_a = OW'(vx_ff[2]) - OW'(vx_ff[0]); op_b = OW'(vy_ff[1]) - OW'(vy_ff[0]);
            end
            3'd2: begin
               op_a = pxq - OW'(vx_ff[0]); op_b = OW'(vy_ff[2]) - OW'(vy_ff[0]);
            end
            3'd3: begin
               op_a = OW'(vx_ff[2]) - OW'(vx_ff[0]); op_b = pyq - OW'(vy_ff[0]);
            end
            3'd4: begin
               op_a = OW'(vx_ff[1]) - OW'(vx_ff[0]); op_b = pyq - OW'(vy_ff[0]);
            end
            default: begin
               op_a = pxq - OW'(vx_ff[0]); op_b = OW'(vy_ff[1]) - OW'(vy_ff[0]);
            end
         endcase
      end
      prod = op_a * op_b;
      if (step_ff == 3'd0 || (state_ff == tdr_pkg::ST_EDGE && !step_ff[0])) begin
         sum = CW'(prod);
      end else if (state_ff == tdr_pkg::ST_EDGE) begin
         sum = acc_ff - CW'(prod);
      end else begin
         sum = acc_ff + CW'(prod);
      end
   end

   // Depth rounding, saturation and the compare with the stored entry.
   always_comb begin
      zsh = (acc_ff + CW'(8192)) >>> 14;
      if (zsh > CW'(32767)) begin
         znew = 16'sh7fff;
      end else if (zsh < -CW'(32768)) begin
         znew = 16'sh8000;
      end else begin
         znew = 16'(zsh);
      end
      nearer    = !zero_ff && ($signed(ram_rdata) < znew);
      slot_free = !rvalid_ff || rsp_if.ready;
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      wipe_in   = wipe_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      idx_in    = idx_ff;
      zero_in   = zero_ff;
      acc_in    = acc_ff;
      a_in      = a_ff;
      s_in      = s_ff;
      t_in      = t_ff;
      rvalid_in = rvalid_ff && !rsp_if.ready;
      rvis_in   = rvis_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      rdepth_in = rdepth_ff;
      rwa_in    = rwa_ff;
      rwb_in    = rwb_ff;
      rwc_in    = rwc_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = tdr_pkg::DEPTH_FAR;
      ram_re    = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         tdr_pkg::ST_WIPE: begin
            ram_we    = 1'b1;
            ram_waddr = wipe_ff;
            wipe_in   = wipe_ff + AW'(1);
            if (wipe_ff == '1) begin
               state_in = tdr_pkg::ST_IDLE;
            end
         end
         tdr_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_if.opcode)
                  tdr_pkg::OP_CLEAR: begin
                     ram_we    = on_screen;
                     ram_waddr = req_idx;
                  end
                  tdr_pkg::OP_TEST: begin
                     px_in    = req_if.pixel_x;
                     py_in    = req_if.pixel_y;
                     idx_in   = req_idx;
                     zero_in  = !on_screen;
                     step_in  = 3'd0;
                     state_in = on_screen ? tdr_pkg::ST_EDGE : tdr_pkg::ST_OUT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         tdr_pkg::ST_EDGE: begin
            acc_in  = sum;
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd1: a_in = sum;
               3'd3: s_in = sum;
               3'd5: begin
                  t_in     = sum;
                  state_in = tdr_pkg::ST_CHECK;
               end
               default: begin
               end
            endcase
         end
         tdr_pkg::ST_CHECK: begin
            ram_re    = 1'b1;
            zero_in   = !covered;
            div_start = covered;
            state_in  = covered ? tdr_pkg::ST_DIV : tdr_pkg::ST_OUT;
         end
         tdr_pkg::ST_DIV: begin
            step_in = 3'd0;
            if (div_b_done) begin
               state_in = tdr_pkg::ST_DEPTH;
            end
         end
         tdr_pkg::ST_DEPTH: begin
            acc_in  = sum;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd2) begin
               state_in = tdr_pkg::ST_OUT;
            end
         end
         tdr_pkg::ST_OUT: begin
            if (slot_free) begin
               ram_we    = nearer;
               ram_wdata = znew;
               rvalid_in = 1'b1;
               rvis_in   = nearer;
               rx_in     = px_ff;
               ry_in     = py_ff;
               rdepth_in = zero_ff ? '0 : znew;
               rwa_in    = zero_ff ? '0 : 16'(wa);
               rwb_in    = zero_ff ? '0 : 16'(wb);
               rwc_in    = zero_ff ? '0 : 16'(wc);
               state_in  = tdr_pkg::ST_IDLE;
            end
         end
         default: state_in = tdr_pkg::ST_IDLE;
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      idx_ff    <= idx_in;
      zero_ff   <= zero_in;
      acc_ff    <= acc_in;
      a_ff      <= a_in;
      s_ff      <= s_in;
      t_ff      <= t_in;
      rvis_ff   <= rvis_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      rdepth_ff <= rdepth_in;
      rwa_ff    <= rwa_in;
      rwb_ff    <= rwb_in;
      rwc_ff    <= rwc_in;
      if (reset) begin
         state_ff  <= tdr_pkg::ST_WIPE;
         wipe_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wipe_ff   <= wipe_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // Vertex registers, cleared by reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (reset) begin
            vx_ff[i] <= '0;
            vy_ff[i] <= '0;
            vz_ff[i] <= '0;
         end else if (load_vtx && (int'(req_if.vertex_index) == i)) begin
            vx_ff[i] <= req_if.vert_x;
            vy_ff[i] <= req_if.vert_y;
            vz_ff[i] <= req_if.vert_z;
         end
      end
   end

   // Channel outputs.
   assign req_if.ready    = (state_ff == tdr_pkg::ST_IDLE);
   assign rsp_if.valid    = rvalid_ff;
   assign rsp_if.visible  = rvis_ff;
   assign rsp_if.out_x    = rx_ff;
   assign rsp_if.out_y    = ry_ff;
   assign rsp_if.depth    = rdepth_ff;
   assign rsp_if.weight_a = rwa_ff;
   assign rsp_if.weight_b = rwb_ff;
   assign rsp_if.weight_c = rwc_ff;

   // The two dividers start together and must finish together.
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      div_b_done == div_c_done)
      else $error("weight dividers out of step");

   // A divider only finishes while the sequencer waits for it.
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_b_done |-> state_ff == tdr_pkg::ST_DIV)
      else $error("divider finished outside the divide state");

   // A depth update at the end of a test always reports a visible pixel.
   a_update_visible: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff == tdr_pkg::ST_OUT) |=> (rsp_if.valid && rsp_if.visible))
      else $error("depth updated without a visible result");

   // A new result only appears as a test finishes.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(state_ff == tdr_pkg::ST_OUT))
      else $error("result appeared outside the output state");

   // No command transfer while the wipe pass runs.
   a_wipe_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == tdr_pkg::ST_WIPE |-> !req_if.ready)
      else $error("command accepted during the wipe pass");

endmodule
